FILE: rtl/core/vtu_pkg.sv
// ----------------------------------------------------------------------------
// vtu_pkg
// Shared types, codes and helpers of the view transform unit.
// ----------------------------------------------------------------------------
package vtu_pkg;

    // Fraction bits of every fixed point value.
    localparam int FRAC_BITS = 16;

    typedef logic signed [31:0] t_word;
    typedef t_word [3:0] t_row;
    typedef t_row  [3:0] t_mat;

    localparam t_word ONE_FX = t_word'(32'sd1 <<< FRAC_BITS);

    typedef enum logic [2:0] {
        OP_TO_DEVICE = 3'd0,
        OP_TO_MODEL  = 3'd1,
        OP_TRANSLATE = 3'd2,
        OP_ROT_CW    = 3'd3,
        OP_ROT_CCW   = 3'd4,
        OP_ZOOM_IN   = 3'd5,
        OP_ZOOM_OUT  = 3'd6,
        OP_RESET     = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        CFG_STEP_DX   = 3'd0,
        CFG_STEP_DY   = 3'd1,
        CFG_STEP_DZ   = 3'd2,
        CFG_ROT_COS   = 3'd3,
        CFG_ROT_SIN   = 3'd4,
        CFG_ZOOM_FAC  = 3'd5,
        CFG_ZOOM_INV  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POINT,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
    } t_out_beat;

    typedef struct packed {
        logic signed [31:0] step_dx;
        logic signed [31:0] step_dy;
        logic signed [31:0] step_dz;
        logic signed [17:0] rot_cos;
        logic signed [17:0] rot_sin;
        logic [30:0]        zoom_factor;
        logic [30:0]        zoom_inverse;
    } t_cfg;

    // Control of one matrix store.
    typedef struct packed {
        logic rotate;
        logic wr;
        logic load;
    } t_mat_ctl;

    function automatic t_mat ident();
        t_mat m;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                m[r][c] = (r == c) ? ONE_FX : '0;
            end
        end
        return m;
    endfunction

    // Negation that saturates the most negative value.
    function automatic t_word sat_neg(t_word v);
        t_word r;
        r = (v == {1'b1, 31'd0}) ? {1'b0, {31{1'b1}}} : -v;
        return r;
    endfunction

endpackage

FILE: rtl/core/vtu_lane.sv
// ----------------------------------------------------------------------------
// vtu_lane
// One dot product lane: four registered products, then a rounded,
// saturated sum.
// ----------------------------------------------------------------------------
module vtu_lane (
    input  logic          i_clk,
    input  logic          i_en,
    input  vtu_pkg::t_row i_a,
    input  vtu_pkg::t_row i_b,
    output vtu_pkg::t_word o_sum
);
    import vtu_pkg::*;

    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] MAXV = 66'sd2147483647;
    localparam logic signed [65:0] MINV = -66'sd2147483648;

    logic signed [63:0] r_prod [4];
    logic signed [65:0] acc;
    logic signed [65:0] shr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= $signed(i_a[k]) * $signed(i_b[k]);
            end
        end
    end

    always_comb begin
        acc = 66'(r_prod[0]) + 66'(r_prod[1]) + 66'(r_prod[2]) + 66'(r_prod[3]);
        shr = (acc + HALF) >>> FRAC_BITS;
        if (shr > MAXV) begin
            o_sum = {1'b0, {31{1'b1}}};
        end else if (shr < MINV) begin
            o_sum = {1'b1, 31'd0};
        end else begin
            o_sum = shr[31:0];
        end
    end

endmodule

FILE: rtl/core/vtu_step_gen.sv
// ----------------------------------------------------------------------------
// vtu_step_gen
// Builds the step matrix of an update and its inverse from the registers.
// ----------------------------------------------------------------------------
module vtu_step_gen (
    input  vtu_pkg::t_op  i_op,
    input  vtu_pkg::t_cfg i_cfg,
    output vtu_pkg::t_mat o_step,
    output vtu_pkg::t_mat o_step_inv
);
    import vtu_pkg::*;

    t_word cs;
    t_word sn;
    t_word zf;
    t_word zg;

    always_comb begin
        cs = t_word'(i_cfg.rot_cos);
        sn = t_word'(i_cfg.rot_sin);
        zf = t_word'({1'b0, i_cfg.zoom_factor});
        zg = t_word'({1'b0, i_cfg.zoom_inverse});
        o_step     = ident();
        o_step_inv = ident();
        case (i_op)
            OP_TRANSLATE: begin
                o_step[0][3]     = i_cfg.step_dx;
                o_step[1][3]     = i_cfg.step_dy;
                o_step[2][3]     = i_cfg.step_dz;
                o_step_inv[0][3] = sat_neg(i_cfg.step_dx);
                o_step_inv[1][3] = sat_neg(i_cfg.step_dy);
                o_step_inv[2][3] = sat_neg(i_cfg.step_dz);
            end
            OP_ROT_CW: begin
                o_step[0][0]     = cs;
                o_step[0][1]     = -sn;
                o_step[1][0]     = sn;
                o_step[1][1]     = cs;
                o_step_inv[0][0] = cs;
                o_step_inv[0][1] = sn;
                o_step_inv[1][0] = -sn;
                o_step_inv[1][1] = cs;
            end
            OP_ROT_CCW: begin
                o_step[0][0]     = cs;
                o_step[0][1]     = sn;
                o_step[1][0]     = -sn;
                o_step[1][1]     = cs;
                o_step_inv[0][0] = cs;
                o_step_inv[0][1] = -sn;
                o_step_inv[1][0] = sn;
                o_step_inv[1][1] = cs;
            end
            OP_ZOOM_IN: begin
                for (int r = 0; r < 3; r++) begin
                    o_step[r][r]     = zf;
                    o_step_inv[r][r] = zg;
                end
            end
            OP_ZOOM_OUT: begin
                for (int r = 0; r < 3; r++) begin
                    o_step[r][r]     = zg;
                    o_step_inv[r][r] = zf;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/core/vtu_mat_reg.sv
// ----------------------------------------------------------------------------
// vtu_mat_reg
// A 4x4 matrix store whose rows rotate while an update streams through it.
// ----------------------------------------------------------------------------
module vtu_mat_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vtu_pkg::t_mat_ctl i_ctl,
    input  vtu_pkg::t_row     i_row,
    input  vtu_pkg::t_mat     i_load,
    output vtu_pkg::t_mat     o_mat
);
    import vtu_pkg::*;

    t_mat r_mat;
    t_mat n_mat;

    // A rotation moves row 0 to the back. A new row lands where its old row
    // sits: third place when a rotation happens in the same cycle, else last.
    always_comb begin
        n_mat = r_mat;
        if (i_ctl.load) begin
            n_mat = i_load;
        end else if (i_ctl.rotate) begin
            n_mat[0] = r_mat[1];
            n_mat[1] = r_mat[2];
            n_mat[2] = i_ctl.wr ? i_row : r_mat[3];
            n_mat[3] = r_mat[0];
        end else if (i_ctl.wr) begin
            n_mat[3] = i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= ident();
        end else begin
            r_mat <= n_mat;
        end
    end

    assign o_mat = r_mat;

endmodule

FILE: rtl/core/view_transform_unit.sv
// ----------------------------------------------------------------------------
// view_transform_unit
// 4x4 homogeneous view transform in fixed point with a tracked inverse.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                                  Beat
//  command   in         i_start, o_busy, i_in                    start & !busy
//  result    out        o_out_valid, o_out                       valid strobe
//  config    in         i_cfg_we, i_cfg_idx, i_cfg_wdata         write enable
//
// Sequence: after its beat a point transform keeps the block busy through
// the point state (products) and the drain state (rounded sum into the
// output register). The result strobe follows the drain state, and the next
// beat can be taken at the edge that ends it. An update keeps the block busy
// through the issue state, which feeds the rows of the view matrix and the
// columns of the inverse one at a time to the eight dot product lanes, and
// the drain state, which writes back the last row. A reset command rebuilds
// both matrices at its beat and leaves the block idle.
// Reset: i_rst_n is synchronous; it restores identity matrices and the
// register defaults.
// Stalls: the receiver cannot stall; each result is marked valid for exactly
// one cycle.
//
// The view matrix M is stored by rows. The inverse N is stored transposed,
// so that its columns also rotate through row 0 of its store. For M = M*S
// lane c takes row 0 of M against column c of S; for N = Si*N lane r takes
// row r of Si against column 0 of N. Each lane group's four sums are
// written back as one row of its store.
module view_transform_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  vtu_pkg::t_in_beat i_in,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_wdata,
    output logic              o_out_valid,
    output vtu_pkg::t_out_beat o_out
);
    import vtu_pkg::*;

    t_state    r_state;
    t_state    n_state;
    logic [1:0] r_cnt;
    t_op       r_op;
    t_row      r_v;
    t_cfg      r_cfg;
    t_cfg      n_cfg;
    t_out_beat r_out;
    logic      r_out_vld;

    logic      accept;
    logic      lane_en;
    logic      out_load;
    logic      upd_op;
    t_mat_ctl  mat_ctl;
    t_mat      m_mat;
    t_mat      nt_mat;
    t_mat      step;
    t_mat      step_inv;
    t_mat      m_load;
    t_mat      nt_load;
    t_word     hw;
    t_word     hh;
    t_row      m_a [4];
    t_row      m_b [4];
    t_row      n_a [4];
    t_row      n_b [4];
    t_row      m_row;
    t_row      n_row;

    assign accept = i_start && (r_state == ST_IDLE);
    assign upd_op = (r_op != OP_TO_DEVICE) && (r_op != OP_TO_MODEL);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_op'(i_in.operation))
                        OP_TO_DEVICE, OP_TO_MODEL: n_state = ST_POINT;
                        OP_RESET:                  n_state = ST_IDLE;
                        default:                   n_state = ST_ISSUE;
                    endcase
                end
            end
            ST_POINT: n_state = ST_DRAIN;
            ST_ISSUE: begin
                if (r_cnt == 2'd3) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        lane_en        = (r_state == ST_POINT) || (r_state == ST_ISSUE);
        mat_ctl.rotate = (r_state == ST_ISSUE);
        mat_ctl.wr     = ((r_state == ST_ISSUE) && (r_cnt != 2'd0))
                         || ((r_state == ST_DRAIN) && upd_op);
        mat_ctl.load   = accept && (t_op'(i_in.operation) == OP_RESET);
        out_load       = (r_state == ST_DRAIN) && !upd_op;
        o_busy         = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= 2'd0;
            r_op      <= OP_TO_DEVICE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= (r_state == ST_ISSUE) ? r_cnt + 2'd1 : 2'd0;
            r_out_vld <= out_load;
            if (accept) begin
                r_op <= t_op'(i_in.operation);
            end
        end
    end

    // The point vector is payload and needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_v <= {ONE_FX, i_in.z, i_in.y, i_in.x};
        end
        if (out_load) begin
            r_out <= {m_row[0], m_row[1], m_row[2], m_row[3]};
        end
    end

    // Configuration registers.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STEP_DX:  n_cfg.step_dx      = i_cfg_wdata;
                CFG_STEP_DY:  n_cfg.step_dy      = i_cfg_wdata;
                CFG_STEP_DZ:  n_cfg.step_dz      = i_cfg_wdata;
                CFG_ROT_COS:  n_cfg.rot_cos      = i_cfg_wdata[17:0];
                CFG_ROT_SIN:  n_cfg.rot_sin      = i_cfg_wdata[17:0];
                CFG_ZOOM_FAC: n_cfg.zoom_factor  = i_cfg_wdata[30:0];
                CFG_ZOOM_INV: n_cfg.zoom_inverse = i_cfg_wdata[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_dx      <= '0;
            r_cfg.step_dy      <= '0;
            r_cfg.step_dz      <= '0;
            r_cfg.rot_cos      <= ONE_FX[17:0];
            r_cfg.rot_sin      <= '0;
            r_cfg.zoom_factor  <= ONE_FX[30:0];
            r_cfg.zoom_inverse <= ONE_FX[30:0];
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // A reset command: a y reflection followed by a shift of (w/2, -h/2).
    // Every product there is by one or minus one, so the matrices are set directly.
    always_comb begin
        hw      = i_in.x >>> 1;
        hh      = i_in.y >>> 1;
        m_load  = ident();
        nt_load = ident();
        m_load[1][1]  = -ONE_FX;
        m_load[0][3]  = hw;
        m_load[1][3]  = hh;
        nt_load[1][1] = -ONE_FX;
        nt_load[3][0] = -hw;
        nt_load[3][1] = hh;
    end

    vtu_step_gen u_step (
        .i_op       (r_op),
        .i_cfg      (r_cfg),
        .o_step     (step),
        .o_step_inv (step_inv)
    );

    vtu_mat_reg u_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mat_ctl),
        .i_row   (m_row),
        .i_load  (m_load),
        .o_mat   (m_mat)
    );

    vtu_mat_reg u_nt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mat_ctl),
        .i_row   (n_row),
        .i_load  (nt_load),
        .o_mat   (nt_mat)
    );

    // Lane operands. During a point transform the M lanes take row i of the
    // chosen matrix against the point; the N lanes' sums then go unused.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) begin
                if (r_state == ST_POINT) begin
                    m_a[i][k] = (r_op == OP_TO_DEVICE) ? m_mat[i][k] : nt_mat[k][i];
                    m_b[i][k] = r_v[k];
                end else begin
                    m_a[i][k] = m_mat[0][k];
                    m_b[i][k] = step[k][i];
                end
                n_a[i][k] = step_inv[i][k];
                n_b[i][k] = nt_mat[0][k];
            end
        end
    end

    for (genvar gi = 0; gi < 4; gi++) begin : g_lane
        vtu_lane u_ml (
            .i_clk (i_clk),
            .i_en  (lane_en),
            .i_a   (m_a[gi]),
            .i_b   (m_b[gi]),
            .o_sum (m_row[gi])
        );
        vtu_lane u_nl (
            .i_clk (i_clk),
            .i_en  (lane_en),
            .i_a   (n_a[gi]),
            .i_b   (n_b[gi]),
            .o_sum (n_row[gi])
        );
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // A result strobe follows the drain of a point transform.
    a_out_after_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($past(r_state) == ST_DRAIN) && ($past(r_op) == OP_TO_DEVICE
                        || $past(r_op) == OP_TO_MODEL))
        else $error("result strobe without a point transform");

    // Writes into a matrix store only happen while an update is in flight.
    a_wr_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mat_ctl.wr |-> upd_op && !mat_ctl.load)
        else $error("matrix write outside an update");

    // An accepted update keeps the block busy in the next cycle.
    a_update_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.operation == OP_TRANSLATE || i_in.operation == OP_ROT_CW
                    || i_in.operation == OP_ROT_CCW || i_in.operation == OP_ZOOM_IN
                    || i_in.operation == OP_ZOOM_OUT)) |=> o_busy)
        else $error("update accepted but block not busy");

    // The issue counter only runs in the issue state.
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ISSUE) |=> (r_cnt == 2'd0) || (r_state == ST_ISSUE))
        else $error("issue counter left running");

endmodule

FILE: tb/sv/view_transform_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// view_transform_unit_tb
// Drives transform commands and register writes into the view transform unit
// and checks every result beat against a matrix model kept in the bench.
// ----------------------------------------------------------------------------

// Holds the view matrix, its inverse and the register copies, and the queue
// of point results still owed by the block.
class vtu_tracker;
    longint mat_fwd [4][4];
    longint mat_inv [4][4];
    longint dx, dy, dz, rc, rs, zf, zi;
    vtu_pkg::t_out_beat owed_points[$];
    int errors;

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        dx = 0; dy = 0; dz = 0;
        rc = 65536; rs = 0; zf = 65536; zi = 65536;
        set_ident(mat_fwd);
        set_ident(mat_inv);
    endfunction

    static function void set_ident(ref longint m [4][4]);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) m[r][c] = (r == c) ? 65536 : 0;
    endfunction

    static function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Exact four-term dot product, rounded once (halves up), then saturated.
    static function longint dot4(longint a0, longint a1, longint a2, longint a3,
                                 longint b0, longint b1, longint b2, longint b3);
        logic signed [71:0] acc;
        acc = 72'(a0) * 72'(b0) + 72'(a1) * 72'(b1) + 72'(a2) * 72'(b2)
            + 72'(a3) * 72'(b3) + 72'sd32768;
        acc = acc >>> 16;
        if (acc > 72'sd2147483647) return 64'sd2147483647;
        if (acc < -72'sd2147483648) return -64'sd2147483648;
        return longint'(acc);
    endfunction

    static function void mul(ref longint d [4][4], input longint a [4][4],
                             input longint b [4][4]);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                d[r][c] = dot4(a[r][0], a[r][1], a[r][2], a[r][3],
                               b[0][c], b[1][c], b[2][c], b[3][c]);
    endfunction

    // M = M * s and N = si * N.
    function void compose(longint s [4][4], longint si [4][4]);
        longint t [4][4];
        mul(t, mat_fwd, s);
        mat_fwd = t;
        mul(t, si, mat_inv);
        mat_inv = t;
    endfunction

    function void shift(longint tx, longint ty, longint tz);
        longint s [4][4];
        longint si [4][4];
        set_ident(s);
        set_ident(si);
        s[0][3] = tx; s[1][3] = ty; s[2][3] = tz;
        si[0][3] = clamp32(-tx); si[1][3] = clamp32(-ty); si[2][3] = clamp32(-tz);
        compose(s, si);
    endfunction

    function void write_reg(vtu_pkg::t_cfg_idx idx, logic [31:0] v);
        case (idx)
            vtu_pkg::CFG_STEP_DX:  dx = longint'(signed'(v));
            vtu_pkg::CFG_STEP_DY:  dy = longint'(signed'(v));
            vtu_pkg::CFG_STEP_DZ:  dz = longint'(signed'(v));
            vtu_pkg::CFG_ROT_COS:  rc = longint'(signed'(v[17:0]));
            vtu_pkg::CFG_ROT_SIN:  rs = longint'(signed'(v[17:0]));
            vtu_pkg::CFG_ZOOM_FAC: zf = longint'({1'b0, v[30:0]});
            vtu_pkg::CFG_ZOOM_INV: zi = longint'({1'b0, v[30:0]});
            default: ;
        endcase
    endfunction

    // Notes one accepted command beat.
    function void note_command(vtu_pkg::t_in_beat b);
        longint a [4][4];
        longint g [4][4];
        longint px, py, pz, hw, hh;
        vtu_pkg::t_out_beat o;
        px = longint'(b.x); py = longint'(b.y); pz = longint'(b.z);
        set_ident(a);
        set_ident(g);
        case (vtu_pkg::t_op'(b.operation))
            vtu_pkg::OP_TO_DEVICE, vtu_pkg::OP_TO_MODEL: begin
                if (b.operation == vtu_pkg::OP_TO_DEVICE) a = mat_fwd;
                else a = mat_inv;
                o.out_x = 32'(dot4(a[0][0], a[0][1], a[0][2], a[0][3], px, py, pz, 65536));
                o.out_y = 32'(dot4(a[1][0], a[1][1], a[1][2], a[1][3], px, py, pz, 65536));
                o.out_z = 32'(dot4(a[2][0], a[2][1], a[2][2], a[2][3], px, py, pz, 65536));
                o.out_w = 32'(dot4(a[3][0], a[3][1], a[3][2], a[3][3], px, py, pz, 65536));
                owed_points.push_back(o);
            end
            vtu_pkg::OP_TRANSLATE: shift(dx, dy, dz);
            vtu_pkg::OP_ROT_CW, vtu_pkg::OP_ROT_CCW: begin
                a[0][0] = rc; a[0][1] = -rs; a[1][0] = rs; a[1][1] = rc;
                g[0][0] = rc; g[0][1] = rs; g[1][0] = -rs; g[1][1] = rc;
                if (b.operation == vtu_pkg::OP_ROT_CW) compose(a, g);
                else compose(g, a);
            end
            vtu_pkg::OP_ZOOM_IN, vtu_pkg::OP_ZOOM_OUT: begin
                for (int r = 0; r < 3; r++) begin
                    a[r][r] = zf;
                    g[r][r] = zi;
                end
                if (b.operation == vtu_pkg::OP_ZOOM_IN) compose(a, g);
                else compose(g, a);
            end
            default: begin
                // Floor halves of width and height, then a y flip and shift.
                hw = px >>> 1;
                hh = py >>> 1;
                set_ident(mat_fwd);
                set_ident(mat_inv);
                a[1][1] = -65536;
                compose(a, a);
                shift(hw, -hh, 0);
            end
        endcase
    endfunction

    // Checks one result beat against the oldest owed point.
    function void check_point(vtu_pkg::t_out_beat got);
        vtu_pkg::t_out_beat want;
        if (owed_points.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            errors++;
            return;
        end
        want = owed_points.pop_front();
        if (got.out_x !== want.out_x) begin
            $display("%0t: out_x expected %0d actual %0d", $time, want.out_x, got.out_x);
            errors++;
        end
        if (got.out_y !== want.out_y) begin
            $display("%0t: out_y expected %0d actual %0d", $time, want.out_y, got.out_y);
            errors++;
        end
        if (got.out_z !== want.out_z) begin
            $display("%0t: out_z expected %0d actual %0d", $time, want.out_z, got.out_z);
            errors++;
        end
        if (got.out_w !== want.out_w) begin
            $display("%0t: out_w expected %0d actual %0d", $time, want.out_w, got.out_w);
            errors++;
        end
    endfunction
endclass

module view_transform_unit_tb;
    import vtu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    t_in_beat   i_in;
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [31:0] i_cfg_wdata;
    logic       o_out_valid;
    t_out_beat  o_out;

    vtu_tracker tracker;
    int cycles;

    view_transform_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Result beats are checked at the edge that ends their strobe cycle.
    // Command beats are noted at the same edge, using the pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid) tracker.check_point(o_out);
            if (i_start && !o_busy) tracker.note_command(i_in);
        end
    end

    // A hard ceiling on the run, in case the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sends one command beat after a random gap and holds it until accepted.
    // Start stays high after the beat; the next gap or wait_idle drops it.
    task automatic send_command(t_op op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in.operation <= op;
        i_in.x <= x;
        i_in.y <= y;
        i_in.z <= z;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Waits until all owed points have arrived and the block has gone quiet;
    // update commands can still be in flight when the last point lands.
    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (tracker.owed_points.size() != 0 || o_busy) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // The write enable stays high across a run of writes; load_regs drops it.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        tracker.write_reg(idx, v);
    endtask

    // Random word biased toward the extremes and small Q16.16 values.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return 32'($signed($urandom_range(0, 40 * 65536)) - 20 * 65536);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_op pick_op();
        int r;
        r = $urandom_range(0, 15);
        if (r < 8) return (r < 4) ? OP_TO_DEVICE : OP_TO_MODEL;
        return t_op'($urandom_range(2, 7));
    endfunction

    // One register set; phase 1 fixes dx and dy, 2 rotation, 3 zoom.
    task automatic load_regs(int phase);
        int ang;
        write_reg(CFG_STEP_DX, phase == 1 ? 32'h7FFF_FFFF : pick_word());
        write_reg(CFG_STEP_DY, phase == 1 ? 32'h8000_0000 : pick_word());
        write_reg(CFG_STEP_DZ, pick_word());
        ang = $urandom_range(0, 65536);
        if (phase == 2) begin
            write_reg(CFG_ROT_COS, 32'hFFFF_0000);
            write_reg(CFG_ROT_SIN, 32'h0001_0000);
        end else begin
            write_reg(CFG_ROT_COS, 32'($signed(ang)));
            write_reg(CFG_ROT_SIN, $urandom);
        end
        if (phase == 3) begin
            write_reg(CFG_ZOOM_FAC, 32'h7FFF_FFFF);
            write_reg(CFG_ZOOM_INV, 32'h0000_0001);
        end else begin
            write_reg(CFG_ZOOM_FAC, $urandom_range(32768, 131072));
            write_reg(CFG_ZOOM_INV, $urandom);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        tracker = new();
        cycles = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity points at the extremes, then each update kind.
        send_command(OP_TO_DEVICE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_command(OP_TO_MODEL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_command(OP_TRANSLATE, 0, 0, 0);
        send_command(OP_ROT_CW, 0, 0, 0);
        send_command(OP_ZOOM_IN, 0, 0, 0);
        send_command(OP_TO_DEVICE, 32'h0001_8000, 32'hFFFF_8000, 32'h0000_0001);
        wait_idle();
        load_regs(1);
        send_command(OP_RESET, 32'h0280_0001, 32'hFE00_0003, 0);
        send_command(OP_TO_DEVICE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_command(OP_TRANSLATE, 0, 0, 0);
        send_command(OP_TO_MODEL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_command(OP_ROT_CCW, 0, 0, 0);
        send_command(OP_ZOOM_OUT, 0, 0, 0);
        send_command(OP_TO_DEVICE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        send_command(OP_RESET, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_command(OP_TO_MODEL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

        // Random phases, each with its own register set; resets keep the
        // matrices from drifting into permanent saturation.
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            load_regs(phase % 4);
            send_command(OP_RESET, pick_word(), pick_word(), pick_word());
            for (int n = 0; n < 172; n++) begin
                if ($urandom_range(0, 24) == 0)
                    send_command(OP_RESET, pick_word(), pick_word(), pick_word());
                else
                    send_command(pick_op(), pick_word(), pick_word(), pick_word());
            end
        end

        wait_idle();
        if (tracker.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
